/* hdl/brg_pkg.sv */
// ----------------------------------------------------------------------------
// Beat rate gate package
// Payload types, register indexes, action and mode codes and the fixed
// constants shared by the beat rate gate and its checker.
// ----------------------------------------------------------------------------
package brg_pkg;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned COUNT_W     = 32;
   localparam int unsigned TIME_W      = 32;
   localparam int unsigned PERIOD_W    = 16;
   localparam int unsigned SKIP_CNT_W  = 17;

   localparam logic [CSR_INDEX_W-1:0] CSR_GATE_MODE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BPM          = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SKIP_AMOUNT  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INITIAL_SKIP = 2'd3;

   localparam logic [1:0] GATE_RATE = 2'd0;
   localparam logic [1:0] GATE_NTH  = 2'd1;
   localparam logic [1:0] GATE_FLIP = 2'd2;

   localparam logic [1:0] ACT_NONE = 2'd0;
   localparam logic [1:0] ACT_SET  = 2'd1;
   localparam logic [1:0] ACT_CLR  = 2'd2;

   localparam logic [PERIOD_W-1:0] MS_PER_MIN   = 16'd60000;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd500;
   localparam logic [CSR_DATA_W-1:0] SKIP_AMOUNT_RESET = 16'd1;
   localparam logic [COUNT_W-1:0] COUNT_MAX     = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [TIME_W-1:0] now_ms;
      logic              beat_in;
      logic              bypass;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]         beat_action;
      logic [COUNT_W-1:0] beats_seen;
      logic [COUNT_W-1:0] beats_emitted;
   } rsp_payload_type;

   typedef struct packed {
      logic                busy;
      logic [PERIOD_W-1:0] period;
   } div_status_type;

endpackage

/* hdl/brg_stream_if.sv */
// ----------------------------------------------------------------------------
// Beat rate gate stream channel
// A valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface brg_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/brg_period_div.sv */
// ----------------------------------------------------------------------------
// Beat rate gate period divider
// Works out 60000 / beats_per_minute one quotient bit a cycle and holds the
// resulting period in milliseconds.
// ----------------------------------------------------------------------------
module brg_period_div import brg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [CSR_DATA_W-1:0] divisor,
   output div_status_type        status
);

   logic                  busy_ff, busy_in;
   logic [3:0]            bit_ff, bit_in;
   logic [PERIOD_W-1:0]   rem_ff, rem_in;
   logic [PERIOD_W-1:0]   quo_ff, quo_in;
   logic [CSR_DATA_W-1:0] divisor_ff, divisor_in;
   logic [PERIOD_W-1:0]   period_ff, period_in;
   logic [PERIOD_W:0]     shifted;
   logic [PERIOD_W:0]     diff;
   logic                  fits;

   always_comb begin
      shifted    = {rem_ff, MS_PER_MIN[bit_ff]};
      diff       = shifted - {1'b0, divisor_ff};
      fits       = shifted >= {1'b0, divisor_ff};
      busy_in    = busy_ff;
      bit_in     = bit_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      period_in  = period_ff;
      if (start) begin
         // A rate of zero is treated as one beat a minute.
         if (divisor == '0) begin
            period_in = MS_PER_MIN;
            busy_in   = 1'b0;
         end else begin
            busy_in    = 1'b1;
            bit_in     = 4'd15;
            rem_in     = '0;
            quo_in     = '0;
            divisor_in = divisor;
         end
      end else if (busy_ff) begin
         rem_in = fits ? diff[PERIOD_W-1:0] : shifted[PERIOD_W-1:0];
         quo_in = {quo_ff[PERIOD_W-2:0], fits};
         bit_in = bit_ff - 4'd1;
         if (bit_ff == 4'd0) begin
            busy_in   = 1'b0;
            period_in = {quo_ff[PERIOD_W-2:0], fits};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         period_ff <= PERIOD_RESET;
      end else begin
         busy_ff   <= busy_in;
         period_ff <= period_in;
      end
      bit_ff     <= bit_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign status.busy   = busy_ff;
   assign status.period = period_ff;

endmodule

/* hdl/beat_rate_gate.sv */
// ----------------------------------------------------------------------------
// Beat rate gate
// Per-frame beat gate: clears the first beats, generates beats at a fixed
// rate, passes every (skip+1)th beat or inverts beats, and counts beats.
// ----------------------------------------------------------------------------
// An input transfer is captured in an input register and its result in a
// result register, with the gating logic between them. One item per cycle
// is taken while the result is not stalled and no period division runs.
// A write to beats_per_minute holds off input in its own cycle and while the
// period division that follows is running. Synchronous reset clears the counts
// and restores the default settings, with a period of 500 ms.
module beat_rate_gate import brg_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   brg_stream_if.sink             req_chan,
   brg_stream_if.source           rsp_chan,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   logic [1:0]            mode_ff;
   logic [CSR_DATA_W-1:0] skip_amount_ff;
   logic [CSR_DATA_W-1:0] initial_skip_ff;

   logic [COUNT_W-1:0]    in_count_ff, in_count_in;
   logic [COUNT_W-1:0]    out_count_ff, out_count_in;
   logic [SKIP_CNT_W-1:0] drop_cnt_ff, drop_cnt_in;
   logic [TIME_W-1:0]     last_time_ff, last_time_in;

   logic                  s1_valid_ff;
   req_payload_type       s1_data_ff;
   logic                  rsp_valid_ff;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   div_status_type        div_status;
   logic                  bpm_write;
   logic                  advance;

   logic [1:0]            action;
   logic [COUNT_W-1:0]    in_count_bumped;
   logic [TIME_W:0]       due_time;
   logic                  fire;
   logic [PERIOD_W:0]     two_period;
   logic [TIME_W-1:0]     resync_edge;
   logic                  resync;
   logic [SKIP_CNT_W-1:0] drop_cnt_bumped;
   logic                  emit;

   assign bpm_write = csr_write_enable && (csr_index == CSR_BPM);

   brg_period_div u_period_div (
      .clock   (clock),
      .reset   (reset),
      .start   (bpm_write),
      .divisor (csr_write_data),
      .status  (div_status)
   );

   assign advance        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !div_status.busy && !bpm_write && (!s1_valid_ff || advance);

   always_comb begin
      in_count_bumped   = (in_count_ff != COUNT_MAX) ? in_count_ff + 32'd1 : in_count_ff;
      due_time          = {1'b0, last_time_ff} + {17'd0, div_status.period};
      fire              = {1'b0, s1_data_ff.now_ms} > due_time;
      two_period        = {div_status.period, 1'b0};
      resync_edge       = s1_data_ff.now_ms - {15'd0, two_period};
      resync            = (s1_data_ff.now_ms < {15'd0, two_period}) ||
                          (last_time_ff < resync_edge);
      drop_cnt_bumped   = drop_cnt_ff + 17'd1;

      action        = ACT_NONE;
      emit          = 1'b0;
      in_count_in   = in_count_ff;
      drop_cnt_in   = drop_cnt_ff;
      last_time_in  = last_time_ff;

      if (!s1_data_ff.bypass) begin
         if (s1_data_ff.beat_in) begin
            in_count_in = in_count_bumped;
         end
         // Beats inside the opening window are only cleared.
         if ((initial_skip_ff != '0) && (in_count_in <= {16'd0, initial_skip_ff})) begin
            action = s1_data_ff.beat_in ? ACT_CLR : ACT_NONE;
         end else begin
            unique case (mode_ff)
               GATE_RATE: begin
                  action = ACT_CLR;
                  if (fire) begin
                     action       = ACT_SET;
                     emit         = 1'b1;
                     last_time_in = resync ? s1_data_ff.now_ms : due_time[TIME_W-1:0];
                  end
               end
               GATE_NTH: begin
                  action = ACT_CLR;
                  if (s1_data_ff.beat_in) begin
                     if (drop_cnt_bumped > {1'b0, skip_amount_ff}) begin
                        drop_cnt_in = '0;
                        action      = ACT_SET;
                        emit        = 1'b1;
                     end else begin
                        drop_cnt_in = drop_cnt_bumped;
                     end
                  end
               end
               GATE_FLIP: begin
                  action = s1_data_ff.beat_in ? ACT_CLR : ACT_SET;
                  emit   = !s1_data_ff.beat_in;
               end
               default: begin
                  action = ACT_NONE;
               end
            endcase
         end
      end

      out_count_in = (emit && (out_count_ff != COUNT_MAX)) ? out_count_ff + 32'd1
                                                           : out_count_ff;

      rsp_data_in.beat_action   = action;
      rsp_data_in.beats_seen    = in_count_in;
      rsp_data_in.beats_emitted = out_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= GATE_RATE;
         skip_amount_ff  <= SKIP_AMOUNT_RESET;
         initial_skip_ff <= '0;
         in_count_ff     <= '0;
         out_count_ff    <= '0;
         drop_cnt_ff     <= '0;
         last_time_ff    <= '0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_GATE_MODE:    mode_ff         <= csr_write_data[1:0];
               CSR_SKIP_AMOUNT:  skip_amount_ff  <= csr_write_data;
               CSR_INITIAL_SKIP: initial_skip_ff <= csr_write_data;
               default: begin
               end
            endcase
         end
         if (advance) begin
            in_count_ff   <= in_count_in;
            out_count_ff  <= out_count_in;
            drop_cnt_ff   <= drop_cnt_in;
            last_time_ff  <= last_time_in;
         end
         if (req_chan.valid && req_chan.ready) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_chan.valid && req_chan.ready) begin
         s1_data_ff <= req_chan.payload;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

endmodule

/* hdl/brg_checker.sv */
// ----------------------------------------------------------------------------
// Beat rate gate checker
// Port-level assertions on the result channel of the beat rate gate.
// ----------------------------------------------------------------------------
module brg_checker import brg_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_beat_action,
   input logic [COUNT_W-1:0] rsp_beats_seen,
   input logic [COUNT_W-1:0] rsp_beats_emitted
);

   // A stalled result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_beats_seen) &&
         $stable(rsp_beats_emitted) && $stable(rsp_beat_action))
      else $error("result changed while stalled");

   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   // A forced beat is always counted.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_beat_action == ACT_SET) |-> rsp_beats_emitted != '0)
      else $error("forced beat with zero emitted count");

   // Back-to-back results never lose count and emit at most one beat each.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid ||
         ((rsp_beats_seen >= $past(rsp_beats_seen)) &&
          (rsp_beats_emitted >= $past(rsp_beats_emitted)) &&
          (rsp_beats_emitted - $past(rsp_beats_emitted) <= 32'd1)))
      else $error("beat counts moved wrongly between results");

endmodule

bind beat_rate_gate brg_checker u_brg_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_beat_action   (rsp_chan.payload.beat_action),
   .rsp_beats_seen    (rsp_chan.payload.beats_seen),
   .rsp_beats_emitted (rsp_chan.payload.beats_emitted)
);
